FILE: hw/rtl/console_line_editor_assert.svh
// Assertion macros used by the console line editor datapath.
`ifndef CONSOLE_LINE_EDITOR_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define CLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define CLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cle_pkg.sv
// Shared types, codes and helper functions of the console line editor.
package cle_pkg;

  // Byte codes
  localparam logic [7:0] BYTE_BS   = 8'h08;
  localparam logic [7:0] BYTE_DEL  = 8'h7F;
  localparam logic [7:0] BYTE_KILL = 8'h15;
  localparam logic [7:0] BYTE_EOT  = 8'h04;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_SP   = 8'h20;

  // Sizes
  localparam int LINE_DEPTH_DEF = 16;
  localparam int LIMIT_W        = 5;
  localparam int LEN_W          = 4;
  localparam int UPC_W          = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Microcode entry points
  localparam logic [UPC_W-1:0] UPC_IDLE  = 5'd0;
  localparam logic [UPC_W-1:0] UPC_ERASE = 5'd1;
  localparam logic [UPC_W-1:0] UPC_KILL  = 5'd5;
  localparam logic [UPC_W-1:0] UPC_EOT   = 5'd9;
  localparam logic [UPC_W-1:0] UPC_LF    = 5'd11;
  localparam logic [UPC_W-1:0] UPC_LOOP  = 5'd12;
  localparam logic [UPC_W-1:0] UPC_EOL   = 5'd14;
  localparam logic [UPC_W-1:0] UPC_CHAR  = 5'd15;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_DATA = 2'd1,
    KIND_EOL  = 2'd2,
    KIND_EOF  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    COND_NEXT     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_CNT_ZERO = 3'd2,
    COND_CNT_NZ   = 3'd3,
    COND_IDX_END  = 3'd4,
    COND_NO_ROOM  = 3'd5,
    COND_DISPATCH = 3'd6
  } cond_t;

  typedef enum logic [2:0] {
    BSEL_ZERO = 3'd0,
    BSEL_BS   = 3'd1,
    BSEL_SP   = 3'd2,
    BSEL_LF   = 3'd3,
    BSEL_CUR  = 3'd4,
    BSEL_RD   = 3'd5
  } bsel_t;

  typedef enum logic [1:0] {
    LAST_NO  = 2'd0,
    LAST_YES = 2'd1,
    LAST_ONE = 2'd2
  } last_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_t;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_CLR  = 2'd1,
    IDX_INC  = 2'd2
  } idx_op_t;

  // One control word of the microprogram
  typedef struct packed {
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic             emit;
    kind_t            kind;
    bsel_t            bsel;
    last_sel_t        last_sel;
    cnt_op_t          cnt_op;
    idx_op_t          idx_op;
    logic             wr;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    ucode_t cw;
    logic   advance;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic cnt_zero;
    logic idx_end;
    logic no_room;
    logic out_busy;
  } flags_t;

  // Turn carriage return into line feed
  function automatic logic [7:0] map_cr(input logic [7:0] b);
    return (b == BYTE_CR) ? BYTE_LF : b;
  endfunction

  // Pick the microprogram entry for a received byte
  function automatic logic [UPC_W-1:0] entry_of(input logic [7:0] b);
    logic [UPC_W-1:0] e;
    case (map_cr(b)) inside
      BYTE_BS, BYTE_DEL: e = UPC_ERASE;
      BYTE_KILL:         e = UPC_KILL;
      BYTE_EOT:          e = UPC_EOT;
      BYTE_LF:           e = UPC_LF;
      default:           e = UPC_CHAR;
    endcase
    return e;
  endfunction

endpackage

FILE: hw/rtl/console_line_editor.sv
// Top level of the console line editor: sequencer plus datapath.
//
// Usage:
//   s_* channel takes one received byte per transaction in s_tdata[7:0].
//   m_* channel returns result items: m_tuser is the kind (echo, line byte,
//   end of line, end of file), m_tdata holds the byte and the line length,
//   m_tlast marks the final result caused by one received byte.
//   cfg_* channel writes line_limit; it is always ready and must only be
//   written while no byte is being processed.
// Timing:
//   A byte is taken when the sequencer sits in its idle step, so the next byte
//   waits until the microprogram of the last one has run. Each emitted result
//   occupies one step of the microprogram. A result appears in the output
//   register in the cycle after its step.
// Reset: line empty, limit 16, output empty. The line store is not cleared.
// Stall: while m_tready is low and a result waits, the emitting step holds.
module console_line_editor #(
  parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // received byte stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,   // [7:0] out_byte, [11:8] line_length, zero
  output logic [1:0]                  m_tuser,   // [1:0] out_kind
  output logic                        m_tlast,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cle_pkg::LIMIT_W-1:0] cfg_data
);
  import cle_pkg::*;

  ctrl_t            ctl;
  flags_t           flags;
  logic [7:0]       res_byte;
  logic [LEN_W-1:0] res_len;

  assign cfg_ready = 1'b1;

  cle_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_ready (s_tready),
    .flags    (flags),
    .ctl      (ctl)
  );

  cle_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .rx_byte   (s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .flags     (flags),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_byte  (res_byte),
    .out_len   (res_len),
    .out_last  (m_tlast)
  );

  // Pack result fields
  assign m_tdata = {4'b0000, res_len, res_byte};

endmodule

FILE: hw/rtl/cle_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module cle_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  output logic            in_ready,
  input  cle_pkg::flags_t flags,
  output cle_pkg::ctrl_t  ctl
);
  import cle_pkg::*;

  logic [UPC_W-1:0] upc, upc_next;
  ucode_t           cw;
  logic             stall;
  logic             taken;

  // Control store
  function automatic ucode_t urom(input logic [UPC_W-1:0] a);
    ucode_t w;
    w = '{cond: COND_NEXT, target: UPC_IDLE, emit: 1'b0, kind: KIND_ECHO,
          bsel: BSEL_ZERO, last_sel: LAST_NO, cnt_op: CNT_HOLD,
          idx_op: IDX_HOLD, wr: 1'b0};
    case (a)
      5'd0:  w.cond = COND_DISPATCH;
      // single erase
      5'd1:  w.cond = COND_CNT_ZERO;
      5'd2:  begin w.emit = 1'b1; w.bsel = BSEL_BS; end
      5'd3:  begin w.emit = 1'b1; w.bsel = BSEL_SP; end
      5'd4:  begin
        w.emit = 1'b1; w.bsel = BSEL_BS; w.last_sel = LAST_YES;
        w.cnt_op = CNT_DEC; w.cond = COND_ALWAYS;
      end
      // line kill loop
      5'd5:  w.cond = COND_CNT_ZERO;
      5'd6:  begin w.emit = 1'b1; w.bsel = BSEL_BS; end
      5'd7:  begin w.emit = 1'b1; w.bsel = BSEL_SP; end
      5'd8:  begin
        w.emit = 1'b1; w.bsel = BSEL_BS; w.last_sel = LAST_ONE;
        w.cnt_op = CNT_DEC; w.cond = COND_ALWAYS; w.target = UPC_KILL;
      end
      // end of file on empty line
      5'd9:  w.cond = COND_CNT_NZ;
      5'd10: begin
        w.emit = 1'b1; w.kind = KIND_EOF; w.last_sel = LAST_YES;
        w.cond = COND_ALWAYS;
      end
      // line feed: echo, deliver, report length
      5'd11: begin w.emit = 1'b1; w.bsel = BSEL_LF; w.idx_op = IDX_CLR; end
      5'd12: begin w.cond = COND_IDX_END; w.target = UPC_EOL; end
      5'd13: begin
        w.emit = 1'b1; w.kind = KIND_DATA; w.bsel = BSEL_RD;
        w.idx_op = IDX_INC; w.cond = COND_ALWAYS; w.target = UPC_LOOP;
      end
      5'd14: begin
        w.emit = 1'b1; w.kind = KIND_EOL; w.last_sel = LAST_YES;
        w.cnt_op = CNT_CLR; w.idx_op = IDX_CLR; w.cond = COND_ALWAYS;
      end
      // plain character
      5'd15: w.cond = COND_NO_ROOM;
      5'd16: begin
        w.emit = 1'b1; w.bsel = BSEL_CUR; w.last_sel = LAST_YES;
        w.cnt_op = CNT_INC; w.wr = 1'b1; w.cond = COND_ALWAYS;
      end
      default: w.cond = COND_ALWAYS;
    endcase
    return w;
  endfunction

  assign cw       = urom(upc);
  assign in_ready = (cw.cond == COND_DISPATCH);
  assign stall    = (cw.emit && flags.out_busy) || (in_ready && !in_valid);

  // Resolve the condition of the current step
  always_comb begin
    case (cw.cond)
      COND_ALWAYS:   taken = 1'b1;
      COND_CNT_ZERO: taken = flags.cnt_zero;
      COND_CNT_NZ:   taken = !flags.cnt_zero;
      COND_IDX_END:  taken = flags.idx_end;
      COND_NO_ROOM:  taken = flags.no_room;
      default:       taken = 1'b0;
    endcase
  end

  // Advance, jump or hold the step counter
  always_comb begin
    if (stall) begin
      upc_next = upc;
    end else if (cw.cond == COND_DISPATCH) begin
      upc_next = entry_of(in_byte);
    end else if (taken) begin
      upc_next = cw.target;
    end else begin
      upc_next = upc + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  assign ctl.cw      = cw;
  assign ctl.advance = !stall;

endmodule

FILE: hw/rtl/cle_datapath.sv
// Datapath: line store, character count, read index and result register.
`include "console_line_editor_assert.svh"

module cle_datapath #(
  parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cle_pkg::ctrl_t               ctl,
  input  logic [7:0]                   rx_byte,
  input  logic                         cfg_we,
  input  logic [cle_pkg::LIMIT_W-1:0]  cfg_data,
  output cle_pkg::flags_t              flags,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_kind,
  output logic [7:0]                   out_byte,
  output logic [cle_pkg::LEN_W-1:0]    out_len,
  output logic                         out_last
);
  import cle_pkg::*;

  localparam int CNT_W = $clog2(LINE_DEPTH);
  localparam int CMP_W = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

  logic [LIMIT_W-1:0] line_limit;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic [7:0]         store [LINE_DEPTH];
  logic [7:0]         rd_data;
  logic [7:0]         cur_byte;
  logic [CMP_W-1:0]   lim_eff;
  logic               no_room;
  logic               fire;
  logic               take;
  logic [7:0]         sel_byte;
  logic               sel_last;

  assign fire = ctl.advance && ctl.cw.emit;
  assign take = ctl.advance && (ctl.cw.cond == COND_DISPATCH);

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      line_limit <= cfg_data;
    end
  end

  // Clamp the limit to the store depth and check for room
  assign lim_eff = (CMP_W'(line_limit) > CMP_W'(LINE_DEPTH)) ? CMP_W'(LINE_DEPTH)
                                                             : CMP_W'(line_limit);
  assign no_room = (CMP_W'(count) + CMP_W'(1)) >= lim_eff;

  // Count and index updates
  always_comb begin
    count_next = count;
    idx_next   = idx;
    if (ctl.advance) begin
      case (ctl.cw.cnt_op)
        CNT_INC: count_next = count + CNT_W'(1);
        CNT_DEC: count_next = count - CNT_W'(1);
        CNT_CLR: count_next = '0;
        default: count_next = count;
      endcase
      case (ctl.cw.idx_op)
        IDX_CLR: idx_next = '0;
        IDX_INC: idx_next = idx + CNT_W'(1);
        default: idx_next = idx;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      count <= count_next;
      idx   <= idx_next;
    end
  end

  // Latch the received byte with carriage return mapped to line feed
  always_ff @(posedge clk) begin
    if (take) begin
      cur_byte <= map_cr(rx_byte);
    end
  end

  // Line store: write at the count, registered read at the index
  always_ff @(posedge clk) begin
    if (ctl.advance && ctl.cw.wr) begin
      store[count] <= cur_byte;
    end
    rd_data <= store[idx];
  end

  // Select result byte and last flag
  always_comb begin
    case (ctl.cw.bsel)
      BSEL_BS:  sel_byte = BYTE_BS;
      BSEL_SP:  sel_byte = BYTE_SP;
      BSEL_LF:  sel_byte = BYTE_LF;
      BSEL_CUR: sel_byte = cur_byte;
      BSEL_RD:  sel_byte = rd_data;
      default:  sel_byte = 8'h00;
    endcase
    case (ctl.cw.last_sel)
      LAST_YES: sel_last = 1'b1;
      LAST_ONE: sel_last = (count == CNT_W'(1));
      default:  sel_last = 1'b0;
    endcase
  end

  // Result register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_kind <= ctl.cw.kind;
      out_byte <= sel_byte;
      out_len  <= (ctl.cw.kind == KIND_EOL) ? LEN_W'(count) : '0;
      out_last <= sel_last;
    end
  end

  assign flags.cnt_zero = (count == '0);
  assign flags.idx_end  = (idx == count);
  assign flags.no_room  = no_room;
  assign flags.out_busy = out_valid && !out_ready;

  // Checks
  `CLE_ASSERT_NOW(a_wr_has_room, ctl.advance && ctl.cw.wr, !no_room,
                  "line store written without room")
  `CLE_ASSERT_NOW(a_idx_in_line, 1'b1, idx <= count,
                  "read index beyond character count")
  `CLE_ASSERT_NEXT(a_eol_empties, fire && (ctl.cw.kind == KIND_EOL), count == '0,
                   "line not emptied after end of line")

endmodule
